@@ design/rde_pkg.sv @@
// Package for the radix digit emitter: widths, defaults, codes and shared types.
// Used by the channel interfaces, the divider, the sequencer and the top level.
// It has no dependencies of its own.
package rde_pkg;

   // Field widths of the channels and the register file.
   localparam int IN_VALUE_W  = 64;
   localparam int RADIX_W     = 5;
   localparam int DIGIT_W     = 4;
   localparam int SYMBOL_W    = 8;
   localparam int COUNT_W     = 7;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_RADIX   = 16;
   localparam int DEF_VALUE_WIDTH = 64;

   // Quotient bits the divider resolves in one clock.
   localparam int DIV_STEP_BITS = 8;

   // Reset value of the radix register.
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

   // Register indexes, taken from paddr[4:3].
   typedef enum logic [1:0] {
      CSR_RADIX   = 2'd0,
      CSR_SYM_LOW = 2'd1,
      CSR_SYM_HIGH = 2'd2
   } csr_index_type;

   // Conversion sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_SEND
   } seq_state_type;

   // Status handed from the divider to the sequencer.
   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

   // Character of one digit from the two packed symbol registers.
   function automatic logic [SYMBOL_W-1:0] symbol_of(
      input logic [DIGIT_W-1:0]    digit,
      input logic [CSR_DATA_W-1:0] sym_low,
      input logic [CSR_DATA_W-1:0] sym_high
   );
      logic [CSR_DATA_W-1:0] word;
      word = digit[DIGIT_W-1] ? sym_high : sym_low;
      return word[SYMBOL_W*digit[DIGIT_W-2:0] +: SYMBOL_W];
   endfunction

endpackage

@@ design/rde_channels.sv @@
// Valid/ready channel interfaces of the radix digit emitter.
// Depends on rde_pkg for the payload widths.

// Request channel: one value to convert per transaction.
interface rde_req_if;
   import rde_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [IN_VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// Response channel: one digit character per transaction.
interface rde_rsp_if;
   import rde_pkg::*;
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                no_symbol;
   logic                last;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output symbol, output no_symbol, output last,
                   output count, input ready);
   modport sink   (input valid, input symbol, input no_symbol, input last,
                   input count, output ready);
endinterface

@@ design/rde_divider.sv @@
// Shared iterative divider: divides the working value by the radix, several
// quotient bits per clock, and returns quotient and remainder.
// Depends on rde_pkg for widths and the status struct.
module rde_divider #(
   parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [VALUE_WIDTH-1:0]       dividend,
   input  logic [rde_pkg::RADIX_W-1:0]  divisor,
   output logic [VALUE_WIDTH-1:0]       quotient,
   output rde_pkg::div_status_type      status
);
   import rde_pkg::*;

   localparam int STEPS  = (VALUE_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int PAD_W  = STEPS * DIV_STEP_BITS;
   localparam int STEP_W = $clog2(STEPS);

   logic [PAD_W-1:0]   work_ff, work_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // Restoring long division over one slice of dividend bits. The partial
   // remainder stays below the divisor, so the trial value fits in RADIX_W bits.
   always_comb begin
      logic [PAD_W-1:0]   work_v;
      logic [DIGIT_W-1:0] rem_v;
      logic [RADIX_W-1:0] trial;
      work_v = work_ff;
      rem_v  = rem_ff;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         trial  = {rem_v, work_v[PAD_W-1]};
         work_v = {work_v[PAD_W-2:0], 1'b0};
         if (trial >= divisor) begin
            rem_v     = DIGIT_W'(trial - divisor);
            work_v[0] = 1'b1;
         end else begin
            rem_v = trial[DIGIT_W-1:0];
         end
      end

      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = PAD_W'(dividend);
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = work_v;
         rem_in  = rem_v;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   // The quotient never exceeds the dividend, so the pad bits are zero.
   assign quotient         = work_ff[VALUE_WIDTH-1:0];
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

@@ design/rde_sequencer.sv @@
// Conversion sequencer: drives the shared divider once per digit, keeps the
// digits in a small memory and plays them back most significant first.
// Depends on rde_pkg and the channel interfaces in rde_channels.sv.
module rde_sequencer #(
   parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   rde_req_if.sink                        req_bus,
   rde_rsp_if.source                      rsp_bus,
   input  logic [rde_pkg::RADIX_W-1:0]    radix_eff,
   input  logic [rde_pkg::CSR_DATA_W-1:0] sym_low,
   input  logic [rde_pkg::CSR_DATA_W-1:0] sym_high,
   output logic                           div_start,
   output logic [VALUE_WIDTH-1:0]         div_dividend,
   input  logic [VALUE_WIDTH-1:0]         div_quotient,
   input  rde_pkg::div_status_type        div_status
);
   import rde_pkg::*;

   localparam int ADDR_W = $clog2(VALUE_WIDTH);
   localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

   seq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   digit_cnt_ff, digit_cnt_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   emit_cnt_ff, emit_cnt_in;
   logic [ADDR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic               invalid_ff, invalid_in;
   logic [DIGIT_W-1:0] rd_data_ff;
   logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

   logic req_fire;
   logic rsp_fire;
   logic digit_done;
   logic final_digit;
   logic send_last;
   logic mem_we;

   assign req_fire    = req_bus.valid && req_bus.ready;
   assign rsp_fire    = rsp_bus.valid && rsp_bus.ready;
   assign digit_done  = (state_ff == ST_DIVIDE) && div_status.done;
   assign final_digit = (div_quotient == '0);
   assign send_last   = invalid_ff || (emit_cnt_ff == total_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (radix_eff < RADIX_W'(2)) ? ST_SEND : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (digit_done && final_digit) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_fire) begin
               state_in = send_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake, divider and memory controls.
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      div_start     = 1'b0;
      div_dividend  = div_quotient;
      mem_we        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            div_dividend  = req_bus.value[VALUE_WIDTH-1:0];
            div_start     = req_bus.valid && (radix_eff >= RADIX_W'(2));
         end
         ST_DIVIDE: begin
            mem_we    = digit_done;
            div_start = digit_done && !final_digit;
         end
         ST_SEND: begin
            rsp_bus.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Counters and playback pointer.
   always_comb begin
      digit_cnt_in = digit_cnt_ff;
      total_in     = total_ff;
      emit_cnt_in  = emit_cnt_ff;
      rd_idx_in    = rd_idx_ff;
      invalid_in   = invalid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               invalid_in   = (radix_eff < RADIX_W'(2));
               digit_cnt_in = '0;
               total_in     = '0;
               emit_cnt_in  = '0;
            end
         end
         ST_DIVIDE: begin
            if (digit_done) begin
               digit_cnt_in = digit_cnt_ff + 1'b1;
               if (final_digit) begin
                  total_in  = digit_cnt_ff + 1'b1;
                  rd_idx_in = digit_cnt_ff[ADDR_W-1:0];
               end
            end
         end
         ST_READ: begin
            emit_cnt_in = emit_cnt_ff + 1'b1;
         end
         ST_SEND: begin
            if (rsp_fire && !send_last) begin
               rd_idx_in = rd_idx_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         digit_cnt_ff <= '0;
         total_ff     <= '0;
         emit_cnt_ff  <= '0;
         rd_idx_ff    <= '0;
         invalid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         digit_cnt_ff <= digit_cnt_in;
         total_ff     <= total_in;
         emit_cnt_ff  <= emit_cnt_in;
         rd_idx_ff    <= rd_idx_in;
         invalid_ff   <= invalid_in;
      end
   end

   // Digit store, least significant digit at address zero.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[digit_cnt_ff[ADDR_W-1:0]] <= div_status.remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_data_ff <= digit_mem[rd_idx_ff];
      end
   end

   // Response payload comes from registers that hold while the sink stalls.
   assign rsp_bus.symbol    = invalid_ff ? '0 : symbol_of(rd_data_ff, sym_low, sym_high);
   assign rsp_bus.no_symbol = invalid_ff;
   assign rsp_bus.last      = send_last;
   assign rsp_bus.count     = COUNT_W'(emit_cnt_ff);

endmodule

@@ design/radix_digit_emitter.sv @@
// Top level of the radix digit emitter: register file, radix clamp, and the
// sequencer with its shared divider.
// Depends on rde_pkg, rde_channels.sv, rde_divider and rde_sequencer.
//
//   Port group  Direction  Transaction
//   req_bus     in         one unsigned value to convert
//   rsp_bus     out        one digit character, most significant first
//   csr_*       in/out     APB writes and reads of radix and symbol table
//
// Each digit takes one pass through the shared divider; playback then reads each
// digit from the store and sends it, and a send waits while rsp_bus is not ready.
// req_bus.ready is high only between conversions; a stalled response holds.
// Reset is synchronous; it restores radix 10 and clears the symbol table.
module radix_digit_emitter #(
   parameter int MAX_RADIX   = rde_pkg::DEF_MAX_RADIX,
   parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   rde_req_if.sink                        req_bus,
   rde_rsp_if.source                      rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rde_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rde_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rde_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rde_pkg::*;

   logic [RADIX_W-1:0]    radix_ff;
   logic [CSR_DATA_W-1:0] sym_low_ff;
   logic [CSR_DATA_W-1:0] sym_high_ff;
   logic [RADIX_W-1:0]    radix_eff;
   logic                  csr_write;
   csr_index_type         csr_index;

   logic                  div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_quotient;
   div_status_type        div_status;

   // Register file: 64-bit registers at byte offsets 0, 8 and 16.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= RADIX_RESET;
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RADIX:    radix_ff    <= csr_pwdata[RADIX_W-1:0];
            CSR_SYM_LOW:  sym_low_ff  <= csr_pwdata;
            CSR_SYM_HIGH: sym_high_ff <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_RADIX:    csr_prdata = CSR_DATA_W'(radix_ff);
         CSR_SYM_LOW:  csr_prdata = sym_low_ff;
         CSR_SYM_HIGH: csr_prdata = sym_high_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // A radix above the supported maximum saturates.
   assign radix_eff = (radix_ff > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_ff;

   rde_sequencer #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .radix_eff    (radix_eff),
      .sym_low      (sym_low_ff),
      .sym_high     (sym_high_ff),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_quotient (div_quotient),
      .div_status   (div_status)
   );

   rde_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix_eff),
      .quotient (div_quotient),
      .status   (div_status)
   );

endmodule

@@ sim/rde_checker.sv @@
// Checker for the radix digit emitter: watches the request, response and register ports,
// predicts the digit transactions of each accepted value and compares them in order.
// Depends on rde_pkg and the channel interfaces in rde_channels.sv.
module rde_checker #(
   parameter int MAX_RADIX   = rde_pkg::DEF_MAX_RADIX,
   parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   rde_req_if                             req_bus,
   rde_rsp_if                             rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [rde_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rde_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int unsigned                    failures,
   output int unsigned                    outstanding,
   output int unsigned                    digits_checked
);
   import rde_pkg::*;

   localparam logic [63:0] VALUE_MASK =
      (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
   localparam int REPORT_LIMIT = 10;

   // One digit transaction as it appears on the response channel.
   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                no_symbol;
      logic                last;
      logic [COUNT_W-1:0]  count;
   } digit_result_type;

   digit_result_type expected_digits[$];

   // Shadow copies of the register file.
   logic [RADIX_W-1:0]    radix_reg;
   logic [CSR_DATA_W-1:0] sym_low_reg;
   logic [CSR_DATA_W-1:0] sym_high_reg;

   int unsigned fail_count;
   int unsigned report_count;
   int unsigned checked_count;

   // Convert one value and queue its digit transactions, most significant first.
   task automatic convert_value(input logic [63:0] raw);
      logic [63:0]        rest;
      logic [63:0]        base;
      logic [63:0]        rem;
      logic [63:0]        word;
      logic [63:0]        shifted;
      logic [DIGIT_W-1:0] digits [0:63];
      logic [DIGIT_W-1:0] d;
      digit_result_type   item;
      int                 n;
      int                 k;
      base = (radix_reg > MAX_RADIX) ? 64'(MAX_RADIX) : 64'(radix_reg);
      if (base < 64'd2) begin
         // An unusable radix gives one empty transaction.
         item.symbol    = '0;
         item.no_symbol = 1'b1;
         item.last      = 1'b1;
         item.count     = '0;
         expected_digits.push_back(item);
      end else begin
         rest = raw & VALUE_MASK;
         n = 0;
         do begin
            rem = rest % base;
            digits[n] = rem[DIGIT_W-1:0];
            rest = rest / base;
            n++;
         end while (rest != 64'd0 && n < 64);
         for (k = n - 1; k >= 0; k--) begin
            d = digits[k];
            word = d[DIGIT_W-1] ? sym_high_reg : sym_low_reg;
            shifted = word >> (8 * d[DIGIT_W-2:0]);
            item.symbol    = shifted[SYMBOL_W-1:0];
            item.no_symbol = 1'b0;
            item.last      = (k == 0);
            item.count     = COUNT_W'(n - k);
            expected_digits.push_back(item);
         end
      end
   endtask

   // Snoop register writes, predict on requests and compare responses.
   always @(posedge clock) begin : watch
      digit_result_type seen;
      digit_result_type want;
      if (reset) begin
         expected_digits.delete();
         radix_reg    = RADIX_RESET;
         sym_low_reg  = '0;
         sym_high_reg = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_W-1:3]))
               CSR_RADIX:    radix_reg    = csr_pwdata[RADIX_W-1:0];
               CSR_SYM_LOW:  sym_low_reg  = csr_pwdata;
               CSR_SYM_HIGH: sym_high_reg = csr_pwdata;
               default: ;
            endcase
         end

         if (req_bus.valid && req_bus.ready)
            convert_value(req_bus.value);

         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.symbol    = rsp_bus.symbol;
            seen.no_symbol = rsp_bus.no_symbol;
            seen.last      = rsp_bus.last;
            seen.count     = rsp_bus.count;
            checked_count++;
            if (expected_digits.size() == 0) begin
               fail_count++;
               if (report_count < REPORT_LIMIT) begin
                  report_count++;
                  $display("ERROR: unexpected digit transaction symbol=%h no_symbol=%b last=%b count=%0d",
                           seen.symbol, seen.no_symbol, seen.last, seen.count);
               end
            end else begin
               want = expected_digits.pop_front();
               if (seen.symbol !== want.symbol || seen.no_symbol !== want.no_symbol ||
                   seen.last !== want.last || seen.count !== want.count) begin
                  fail_count++;
                  if (report_count < REPORT_LIMIT) begin
                     report_count++;
                     $display("ERROR: digit mismatch expected symbol=%h no_symbol=%b last=%b count=%0d",
                              want.symbol, want.no_symbol, want.last, want.count);
                     $display("                      actual symbol=%h no_symbol=%b last=%b count=%0d",
                              seen.symbol, seen.no_symbol, seen.last, seen.count);
                  end
               end
            end
         end
      end
      failures       <= fail_count;
      outstanding    <= expected_digits.size();
      digits_checked <= checked_count;
   end

endmodule

@@ sim/tb.sv @@
// Testbench top for the radix digit emitter: clock, reset, register writes, request and
// response idling, and the verdict. Depends on rde_pkg, rde_channels.sv and rde_checker.
module tb;
   import rde_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_RADIX    = {CSR_RADIX, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SYM_LOW  = {CSR_SYM_LOW, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SYM_HIGH = {CSR_SYM_HIGH, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED   = 5'd24;

   // Characters '0'..'7' and '8','9','A'..'F', one byte per digit value.
   localparam logic [63:0] HEX_LOW  = 64'h3736353433323130;
   localparam logic [63:0] HEX_HIGH = 64'h4645444342413938;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 100;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 12;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned mismatch_total;
   int unsigned pending_total;
   int unsigned digit_count;
   int unsigned values_sent;
   int unsigned csr_writes;
   bit          calm;

   rde_req_if req_bus();
   rde_rsp_if rsp_bus();

   radix_digit_emitter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rde_checker digit_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .failures       (mismatch_total),
      .outstanding    (pending_total),
      .digits_checked (digit_count)
   );

   always #5 clock = ~clock;

   // Idle length: mostly none or short, now and then long, none at all in calm phases.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Values spread over full width, narrow ranges, powers of two and the values one below them.
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = {$urandom, $urandom};
         3:       v = 64'($urandom_range(0, 40));
         4:       v = {32'd0, $urandom};
         5:       v = 64'd1 << $urandom_range(0, 63);
         6:       v = (64'd1 << $urandom_range(1, 63)) - 64'd1;
         7:       v = ALL_ONES;
         default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      return v;
   endfunction

   // Radix mostly in the usable range, sometimes too small or above the maximum.
   function automatic logic [RADIX_W-1:0] pick_radix();
      case ($urandom_range(0, 9))
         0:       return RADIX_W'($urandom_range(0, 1));
         1:       return RADIX_W'($urandom_range(17, 31));
         default: return RADIX_W'($urandom_range(2, 16));
      endcase
   endfunction

   // One register write: setup cycle, access cycle, then back to idle.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_writes++;
      @(posedge clock);
   endtask

   // Present one value after a random gap and hold it until the transaction completes.
   task automatic send_value(input logic [63:0] v);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      values_sent++;
   endtask

   // Stop sending and wait until every predicted digit has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_total != 0) @(posedge clock);
   endtask

   // Quiet point for register writes.
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side: ready drops for random stretches.
   initial begin : ready_gen
      int unsigned stall_left;
      int unsigned gap;
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               stall_left = gap - 1;
            end
         end
      end
   end

   // Stimulus: directed corner cases, then random phases under changing settings.
   initial begin : stimulus
      int phase;
      int i;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      calm          <= 1'b0;
      values_sent = 0;
      csr_writes  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: radix ten with an all-zero symbol table.
      send_value(64'd0);
      send_value(ALL_ONES);
      settle();

      // Decimal with readable symbols, including the value zero.
      csr_write(ADDR_SYM_LOW, HEX_LOW);
      csr_write(ADDR_SYM_HIGH, HEX_HIGH);
      csr_write(ADDR_RADIX, 64'd10);
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'd9);
      send_value(64'd10);
      send_value(ALL_ONES);
      send_value(64'h8000_0000_0000_0000);
      settle();

      // Binary gives the longest digit strings.
      csr_write(ADDR_RADIX, 64'd2);
      send_value(64'd0);
      send_value(ALL_ONES);
      send_value(64'd1);
      settle();

      // Hexadecimal with the upper symbols all ones.
      csr_write(ADDR_SYM_HIGH, ALL_ONES);
      csr_write(ADDR_RADIX, 64'd16);
      send_value(ALL_ONES);
      send_value(64'h0123_4567_89AB_CDEF);
      settle();

      // Radix too small, and radix above the maximum which saturates.
      csr_write(ADDR_RADIX, 64'd0);
      send_value(64'd12345);
      settle();
      csr_write(ADDR_RADIX, 64'd1);
      send_value(ALL_ONES);
      settle();
      csr_write(ADDR_RADIX, 64'd17);
      send_value(64'hFEDC_BA98_7654_3210);
      settle();
      csr_write(ADDR_RADIX, 64'd31);
      send_value(64'd255);
      settle();

      // A write to an unused address leaves the settings alone.
      csr_write(ADDR_UNUSED, 64'd3);
      send_value(64'd1000);
      settle();

      // Random phases with random radix, symbol table and idling.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         calm <= ($urandom_range(0, 3) == 0);
         csr_write(ADDR_RADIX,
                   {$urandom, 27'($urandom_range(0, 134217727)), pick_radix()});
         if ($urandom_range(0, 3) != 0)
            csr_write(ADDR_SYM_LOW, {$urandom, $urandom});
         if ($urandom_range(0, 3) != 0)
            csr_write(ADDR_SYM_HIGH, {$urandom, $urandom});
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_value(pick_value());
            if ($urandom_range(0, 14) == 0)
               drain();
         end
         settle();
      end

      drain();
      repeat (END_CYCLES) @(posedge clock);
      $display("Converted %0d values into %0d checked digit transactions,", values_sent,
               digit_count);
      $display("over %0d register writes covering radix 0 to 31 and varied symbol tables.",
               csr_writes);
      if (mismatch_total == 0 && pending_total == 0) begin
         $display("radix_digit_emitter verification clean");
      end else begin
         $display("radix_digit_emitter verification failed");
      end
      $finish;
   end

   // Hard stop if the run hangs.
   initial begin : watchdog
      #20000000;
      $display("radix_digit_emitter verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/rde_pkg.sv
design/rde_channels.sv
design/rde_divider.sv
design/rde_sequencer.sv
design/radix_digit_emitter.sv
sim/rde_checker.sv
sim/tb.sv
